### src/tfd_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer package
// Shared constants and the result payload type.
// ----------------------------------------------------------------------------
package tfd_pkg;

   localparam int unsigned POS_W         = 17;
   localparam logic [7:0]  SYNC_BYTE     = 8'h3C;
   localparam logic [POS_W-1:0] POS_HUNT = 17'd0;
   localparam logic [POS_W-1:0] POS_TYPE = 17'd1;
   localparam logic [POS_W-1:0] POS_LEN_LO = 17'd2;
   localparam logic [POS_W-1:0] POS_LEN_HI = 17'd3;
   localparam logic [POS_W-1:0] POS_BODY = 17'd4;
   localparam logic [15:0] MAX_LEN_RESET = 16'd255;
   localparam logic [15:0] HEADER_LAST   = 16'd3;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_LEN_ERR = 1'b1;

   typedef struct packed {
      logic        status;
      logic [7:0]  frame_type;
      logic [15:0] frame_length;
      logic [31:0] object_id;
   } rsp_type;

endpackage

### src/tfd_if.sv
// ----------------------------------------------------------------------------
// Deframer channel interfaces
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface tfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [7:0]  frame_type;
   logic [15:0] frame_length;
   logic [31:0] object_id;

   modport source (output valid, output status, output frame_type,
                   output frame_length, output object_id, input ready);
   modport sink   (input valid, input status, input frame_type,
                   input frame_length, input object_id, output ready);
endinterface

### src/telemetry_frame_deframer.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer
// Hunts for the sync byte, parses type, length and object id from the
// byte stream and reports one result per completed or rejected frame.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_ch    in         valid/ready         rx_byte
//  rsp_ch    out        valid/ready         status, frame_type, frame_length,
//                                           object_id
//  csr_*     in         write enable only   max_frame_length (16 bits)
//
//  One byte is taken per cycle while ready; each result is registered.
//  A two-entry output buffer (result register plus skid) lets bytes keep
//  flowing while a result waits; req_ch.ready drops only when both are full.
//  Synchronous reset returns to the sync hunt and empties the output buffer.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer
   import tfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   tfd_req_if.sink          req_ch,
   tfd_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       type_ff, type_in;
   logic [15:0]      len_ff, len_in;
   logic [31:0]      id_ff, id_in;
   logic [15:0]      max_len_ff;

   rsp_type          main_ff, skid_ff, res;
   logic             main_v_ff, skid_v_ff;

   logic             accept, push, pop;
   logic [7:0]       b;

   assign req_ch.ready = !skid_v_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = main_v_ff && rsp_ch.ready;
   assign b            = req_ch.rx_byte;

   always_comb begin
      pos_in  = pos_ff;
      type_in = type_ff;
      len_in  = len_ff;
      id_in   = id_ff;
      push    = 1'b0;
      res.status       = STATUS_DONE;
      res.frame_type   = type_ff;
      res.frame_length = len_ff;
      res.object_id    = id_ff;

      if (pos_ff == POS_HUNT) begin
         if (b == SYNC_BYTE) begin
            pos_in = POS_TYPE;
         end
      end else if (pos_ff < POS_BODY) begin
         case (pos_ff[1:0])
            2'd1:    type_in = b;
            2'd2:    len_in  = {len_ff[15:8], b};
            2'd3:    len_in  = {b, len_ff[7:0]};
            default: type_in = type_ff;
         endcase
         pos_in = pos_ff + 1'b1;
         if (pos_ff == POS_LEN_HI) begin
            if (len_in > max_len_ff) begin
               push   = 1'b1;
               pos_in = POS_HUNT;
               res.status = STATUS_LEN_ERR;
            end else if (len_in <= HEADER_LAST) begin
               push   = 1'b1;
               pos_in = POS_HUNT;
            end
         end
      end else begin
         // id bytes sit at frame positions four to seven
         if (pos_ff[POS_W-1:2] == 15'd1) begin
            case (pos_ff[1:0])
               2'd0:    id_in[7:0]   = b;
               2'd1:    id_in[15:8]  = b;
               2'd2:    id_in[23:16] = b;
               default: id_in[31:24] = b;
            endcase
         end
         if (pos_ff >= {1'b0, len_ff}) begin
            push   = 1'b1;
            pos_in = POS_HUNT;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end

      res.frame_type   = type_in;
      res.frame_length = len_in;
      res.object_id    = (res.status == STATUS_LEN_ERR) ? 32'd0 : id_in;
      push = push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_HUNT;
         type_ff    <= 8'd0;
         len_ff     <= 16'd0;
         id_ff      <= 32'd0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         if (accept) begin
            pos_ff  <= pos_in;
            type_ff <= type_in;
            len_ff  <= len_in;
            id_ff   <= id_in;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   // output buffer: skid only fills while the result register is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (pop || !main_v_ff) begin
         if (skid_v_ff) begin
            main_v_ff <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            main_v_ff <= push;
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !main_v_ff) begin
         main_ff <= skid_v_ff ? skid_ff : res;
      end else if (push) begin
         skid_ff <= res;
      end
   end

   assign rsp_ch.valid        = main_v_ff;
   assign rsp_ch.status       = main_ff.status;
   assign rsp_ch.frame_type   = main_ff.frame_type;
   assign rsp_ch.frame_length = main_ff.frame_length;
   assign rsp_ch.object_id    = main_ff.object_id;

endmodule

### src/tfd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the top level's ports and flags illegal behaviour over time.
// ----------------------------------------------------------------------------
module tfd_checker
   import tfd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [7:0]  rsp_frame_type,
   input logic [15:0] rsp_frame_length,
   input logic [31:0] rsp_object_id
);

   // empty output buffer straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // hold a stalled result transaction
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame_type) && $stable(rsp_frame_length)
         && $stable(rsp_object_id))
      else $error("stalled result changed");

   // a fresh result must follow an accepted byte
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an accepted byte");

   // back-pressure only when a result is pending
   a_ready_gap: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

   a_err_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_LEN_ERR |-> rsp_object_id == 32'd0)
      else $error("length error with non-zero object id");

endmodule

bind telemetry_frame_deframer tfd_checker u_tfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_frame_type   (rsp_ch.frame_type),
   .rsp_frame_length (rsp_ch.frame_length),
   .rsp_object_id    (rsp_ch.object_id)
);

### tb/tb_telemetry_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame deframer testbench
// Feeds byte streams of frames, header errors and line noise through the
// deframer under several maximum-length settings and idling patterns, and
// checks every frame result against a tracking model or a typed-in result.
// ----------------------------------------------------------------------------
module tb_telemetry_frame_deframer;
   import tfd_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam rsp_type NO_RSP = '0;

   typedef struct {
      logic [7:0] rx;
      bit         typed;
      rsp_type    want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   tfd_req_if req_ch ();
   tfd_rsp_if rsp_ch ();

   telemetry_frame_deframer uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // tracking copy of the deframer state
   logic [POS_W-1:0] trk_pos;
   logic [7:0]       trk_type;
   logic [15:0]      trk_len;
   logic [31:0]      trk_id;
   logic [15:0]      trk_max_len;

   rsp_type pending_frames[$];

   // tag that travels with a directed byte carrying a typed-in result
   bit      byte_tagged;
   rsp_type byte_tag_rsp;

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int bytes_taken;
   int frames_done;
   int len_errors;
   int quiet_cycles;

   dir_row_type dir_rows [0:24];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic note_mismatch(input string msg);
      error_count++;
      if (error_count <= 100)
         $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // Advance the tracking state by one byte; return 1 when a result is due.
   function automatic bit deframe_byte(input logic [7:0] b, output rsp_type r);
      logic [POS_W-1:0] nxt;
      int               sh;
      r = NO_RSP;
      if (trk_pos == POS_HUNT) begin
         if (b == SYNC_BYTE)
            trk_pos = POS_TYPE;
         return 1'b0;
      end
      if (trk_pos < POS_BODY) begin
         case (trk_pos)
            POS_TYPE:   trk_type = b;
            POS_LEN_LO: trk_len[7:0] = b;
            default:    trk_len[15:8] = b;
         endcase
         nxt = trk_pos + 1'b1;
         if (nxt == POS_BODY) begin
            r.frame_type   = trk_type;
            r.frame_length = trk_len;
            if (trk_len > trk_max_len) begin
               trk_pos = POS_HUNT;
               r.status = STATUS_LEN_ERR;
               return 1'b1;
            end
            if (trk_len <= HEADER_LAST) begin
               trk_pos = POS_HUNT;
               r.status    = STATUS_DONE;
               r.object_id = trk_id;
               return 1'b1;
            end
         end
         trk_pos = nxt;
         return 1'b0;
      end
      if (trk_pos < POS_BODY + 4) begin
         sh = int'(trk_pos - POS_BODY) * 8;
         trk_id[sh +: 8] = b;
      end
      nxt = trk_pos + 1'b1;
      if (nxt > {1'b0, trk_len}) begin
         trk_pos = POS_HUNT;
         r.status       = STATUS_DONE;
         r.frame_type   = trk_type;
         r.frame_length = trk_len;
         r.object_id    = trk_id;
         return 1'b1;
      end
      trk_pos = nxt;
      return 1'b0;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b, input bit tag_on, input rsp_type tag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      byte_tagged    <= tag_on;
      byte_tag_rsp   <= tag;
      @(posedge clock);
      while (req_ch.ready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the sender off until every outstanding result has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_frames.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_max_len(input logic [15:0] value);
      drain_results();
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      trk_max_len = value;
   endtask

   task automatic send_header(input logic [15:0] flen);
      send_byte(SYNC_BYTE, 1'b0, NO_RSP);
      send_byte(8'($urandom_range(255)), 1'b0, NO_RSP);
      send_byte(flen[7:0], 1'b0, NO_RSP);
      send_byte(flen[15:8], 1'b0, NO_RSP);
   endtask

   task automatic random_traffic(input int n_items);
      int          sent;
      int          kind;
      int          cap;
      int          k;
      logic [15:0] flen;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 3) begin
            drain_results();
         end else if (kind < 15 && trk_max_len != 16'hFFFF) begin
            // line noise, sometimes a header cut short
            if ($urandom_range(1) == 1) begin
               send_byte(SYNC_BYTE, 1'b0, NO_RSP);
               sent++;
            end
            k = $urandom_range(4, 1);
            repeat (k)
               send_byte(8'($urandom_range(255)), 1'b0, NO_RSP);
            sent += k;
         end else if (kind < 30 && trk_max_len != 16'hFFFF) begin
            if ($urandom_range(1) == 1)
               flen = trk_max_len + 1'b1;
            else
               flen = 16'($urandom_range(65535, int'(trk_max_len) + 1));
            send_header(flen);
            sent += 4;
         end else begin
            cap = (trk_max_len < 16'd24) ? int'(trk_max_len) : 24;
            flen = ($urandom_range(5) == 0) ? 16'(cap) : 16'($urandom_range(cap, 0));
            send_header(flen);
            for (k = 4; k <= int'(flen); k++)
               send_byte(8'($urandom_range(255)), 1'b0, NO_RSP);
            sent += (flen > HEADER_LAST) ? int'(flen) + 1 : 4;
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      rsp_type predicted;
      bit      produced;
      bit      fired;
      if (!reset) begin
         fired = 1'b0;
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            fired = 1'b1;
            got.status       = rsp_ch.status;
            got.frame_type   = rsp_ch.frame_type;
            got.frame_length = rsp_ch.frame_length;
            got.object_id    = rsp_ch.object_id;
            if (pending_frames.size() == 0) begin
               note_mismatch($sformatf("result with nothing expected: %p", got));
            end else begin
               want = pending_frames.pop_front();
               if (want.status == STATUS_LEN_ERR)
                  len_errors++;
               else
                  frames_done++;
               if (got.status !== want.status)
                  note_mismatch($sformatf("status %0b, expected %0b",
                                          got.status, want.status));
               if (got.frame_type !== want.frame_type)
                  note_mismatch($sformatf("frame_type %h, expected %h",
                                          got.frame_type, want.frame_type));
               if (got.frame_length !== want.frame_length)
                  note_mismatch($sformatf("frame_length %h, expected %h",
                                          got.frame_length, want.frame_length));
               if (got.object_id !== want.object_id)
                  note_mismatch($sformatf("object_id %h, expected %h",
                                          got.object_id, want.object_id));
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            fired = 1'b1;
            bytes_taken++;
            produced = deframe_byte(req_ch.rx_byte, predicted);
            if (byte_tagged)
               pending_frames.push_back(byte_tag_rsp);
            else if (produced)
               pending_frames.push_back(predicted);
         end
         if (fired) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
               $display("tb_telemetry_frame_deframer: errors");
               $finish;
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 16'h0000;
      byte_tagged    = 1'b0;
      byte_tag_rsp   = NO_RSP;
      trk_pos        = POS_HUNT;
      trk_type       = 8'h00;
      trk_len        = 16'h0000;
      trk_id         = 32'h0;
      trk_max_len    = MAX_LEN_RESET;
      error_count    = 0;
      bytes_taken    = 0;
      frames_done    = 0;
      len_errors     = 0;
      quiet_cycles   = 0;
      send_idle_pct  = 23;
      recv_idle_pct  = 56;

      dir_rows = '{
         '{8'h00, 1'b0, NO_RSP},      // dropped while hunting
         '{8'hFF, 1'b0, NO_RSP},
         '{SYNC_BYTE, 1'b0, NO_RSP},  // header with length one above the reset maximum
         '{8'hFF, 1'b0, NO_RSP},
         '{8'h00, 1'b0, NO_RSP},
         '{8'h01, 1'b1, '{STATUS_LEN_ERR, 8'hFF, 16'h0100, 32'h0}},
         '{SYNC_BYTE, 1'b0, NO_RSP},  // zero length: done on the last header byte
         '{8'h00, 1'b0, NO_RSP},
         '{8'h00, 1'b0, NO_RSP},
         '{8'h00, 1'b1, '{STATUS_DONE, 8'h00, 16'h0000, 32'h0}},
         '{SYNC_BYTE, 1'b0, NO_RSP},  // full frame with all four id bytes
         '{8'hA5, 1'b0, NO_RSP},
         '{8'h08, 1'b0, NO_RSP},
         '{8'h00, 1'b0, NO_RSP},
         '{8'h78, 1'b0, NO_RSP},
         '{8'h56, 1'b0, NO_RSP},
         '{8'h34, 1'b0, NO_RSP},
         '{8'h12, 1'b0, NO_RSP},
         '{8'hC3, 1'b1, '{STATUS_DONE, 8'hA5, 16'h0008, 32'h12345678}},
         '{SYNC_BYTE, 1'b0, NO_RSP},  // short frame: upper id bytes carried over
         '{8'h5A, 1'b0, NO_RSP},
         '{8'h05, 1'b0, NO_RSP},
         '{8'h00, 1'b0, NO_RSP},
         '{8'hEE, 1'b0, NO_RSP},
         '{8'hDD, 1'b0, NO_RSP}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

      write_max_len(16'd20);
      random_traffic(330);

      send_idle_pct = 56;
      recv_idle_pct = 23;
      write_max_len(16'd0);
      random_traffic(150);
      write_max_len(16'hFFFF);
      random_traffic(250);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_max_len(16'd9);
      random_traffic(300);

      drain_results();
      repeat (8) @(negedge clock);

      $display("covered %0d bytes: %0d complete frames, %0d length errors",
               bytes_taken, frames_done, len_errors);
      $display("max length settings 255, 20, 0, 65535, 9; %0d mismatches", error_count);
      if (error_count == 0 && pending_frames.size() == 0)
         $display("tb_telemetry_frame_deframer: clean");
      else
         $display("tb_telemetry_frame_deframer: errors");
      $finish;
   end

endmodule
